// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the RTL file that carries checks.
// Both need a clock named clk in scope, HT_ASSERT also a reset named rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define HT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define HT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/htfi_pkg.sv =====
// ----------------------------------------------------------------------------
// htfi_pkg
// Types, codes and constants shared by the hash table find-or-insert block.
// ----------------------------------------------------------------------------
`default_nettype none

package htfi_pkg;

  localparam int KEY_W    = 64;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 12;
  localparam int COUNT_W  = 13;
  localparam int HALF_W   = KEY_W / 2;

  localparam int DEF_TABLE_ENTRIES = 4096;
  localparam int DEF_MAX_PROBES    = 64;

  // Murmur finalizer constants and shift.
  localparam logic [KEY_W-1:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [KEY_W-1:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
  localparam int MIX_SHIFT = 33;

  // Slot reduction for a table size that is not a power of two.
  localparam int MOD_BITS  = 8;
  localparam int MOD_STEPS = KEY_W / MOD_BITS;

  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO_KEY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

  // Partial products of one 64x64 multiply, low 64 bits kept.
  typedef enum logic [1:0] {
    MUL_LL,   // v[31:0]  * c[31:0]
    MUL_LH,   // v[31:0]  * c[63:32], added at bit 32
    MUL_HL    // v[63:32] * c[31:0],  added at bit 32, then xor-shift
  } mul_phase_t;

  typedef struct packed {
    logic                load;
    logic                mul_en;
    mul_phase_t          mul_phase;
    logic                mul_const;
    logic                mod_en;
    logic                home;
    logic                advance;
    logic                insert;
    logic                clr_start;
    logic                clr_en;
    logic                cnt_clr;
    logic                cnt_inc;
    logic                slot_load;
    logic                out_load;
    logic [STATUS_W-1:0] out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic empty;
    logic clr_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/htfi_dp.sv =====
// ----------------------------------------------------------------------------
// htfi_dp
// Datapath: key mixer with one shared 32x32 multiplier, slot reduction,
// key table memory, probe pointer, entry count and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module htfi_dp #(
  parameter int TABLE_ENTRIES = htfi_pkg::DEF_TABLE_ENTRIES
) (
  input  wire logic                          clk,
  input  wire htfi_pkg::dp_cmd_t             cmd_i,
  input  wire logic [htfi_pkg::KEY_W-1:0]    key,
  output htfi_pkg::dp_stat_t                 stat_o,
  output logic      [htfi_pkg::STATUS_W-1:0] status,
  output logic      [htfi_pkg::SLOT_W-1:0]   slot_index,
  output logic      [htfi_pkg::COUNT_W-1:0]  entry_count
);
  import htfi_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [IDX_W:0]   ENT_EXT   = (IDX_W+1)'(TABLE_ENTRIES);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(TABLE_ENTRIES);

  logic [KEY_W-1:0] mem [TABLE_ENTRIES];

  logic [KEY_W-1:0]  key_reg;
  logic [KEY_W-1:0]  v;
  logic [KEY_W-1:0]  acc;
  logic [IDX_W-1:0]  r;
  logic [IDX_W-1:0]  pos;
  logic [IDX_W-1:0]  pos_q;
  logic [IDX_W-1:0]  res_slot;
  logic [KEY_W-1:0]  rdata;
  logic [CNT_W-1:0]  count;

  logic [HALF_W-1:0] mul_a;
  logic [HALF_W-1:0] mul_b;
  logic [KEY_W-1:0]  mul_c;
  logic [KEY_W-1:0]  prod;
  logic [KEY_W-1:0]  sum;
  logic [IDX_W-1:0]  r_new;
  logic [IDX_W-1:0]  pos_inc;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [KEY_W-1:0]  wdata;

  assign mul_c = cmd_i.mul_const ? MIX_C2 : MIX_C1;

  always_comb begin
    case (cmd_i.mul_phase)
      MUL_LL: begin
        mul_a = v[HALF_W-1:0];
        mul_b = mul_c[HALF_W-1:0];
      end
      MUL_LH: begin
        mul_a = v[HALF_W-1:0];
        mul_b = mul_c[KEY_W-1:HALF_W];
      end
      MUL_HL: begin
        mul_a = v[KEY_W-1:HALF_W];
        mul_b = mul_c[HALF_W-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = KEY_W'(mul_a) * KEY_W'(mul_b);
  assign sum  = acc + {prod[HALF_W-1:0], {HALF_W{1'b0}}};

  // Remainder by the table size, one byte of the hash per step.
  always_comb begin
    logic [IDX_W:0]   t;
    logic [IDX_W-1:0] rt;
    rt = r;
    for (int i = 0; i < MOD_BITS; i++) begin
      t = {rt, v[KEY_W-1-i]};
      if (t >= ENT_EXT) begin
        t = t - ENT_EXT;
      end
      rt = t[IDX_W-1:0];
    end
    r_new = rt;
  end

  assign pos_inc = (pos == LAST_IDX) ? '0 : pos + 1'b1;

  assign we    = cmd_i.clr_en | cmd_i.insert;
  assign waddr = cmd_i.clr_en ? pos : pos_q;
  assign wdata = cmd_i.clr_en ? '0 : key_reg;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[pos];
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      key_reg  <= key;
      v        <= key ^ (key >> MIX_SHIFT);
      r        <= '0;
      res_slot <= '0;
    end else if (cmd_i.mul_en) begin
      if (cmd_i.mul_phase == MUL_LL) begin
        acc <= prod;
      end else if (cmd_i.mul_phase == MUL_LH) begin
        acc <= sum;
      end else begin
        v <= sum ^ (sum >> MIX_SHIFT);
      end
    end else if (cmd_i.mod_en) begin
      r <= r_new;
      v <= v << MOD_BITS;
    end

    if (cmd_i.load || cmd_i.clr_start) begin
      pos <= '0;
    end else if (cmd_i.home) begin
      pos <= IS_POW2 ? v[IDX_W-1:0] : r;
    end else if (cmd_i.advance || cmd_i.clr_en) begin
      pos <= pos_inc;
    end
    if (cmd_i.advance) begin
      pos_q <= pos;
    end

    if (cmd_i.slot_load) begin
      res_slot <= pos_q;
    end

    if (cmd_i.cnt_clr) begin
      count <= '0;
    end else if (cmd_i.cnt_inc && count < CNT_LIMIT) begin
      count <= count + 1'b1;
    end

    if (cmd_i.out_load) begin
      status      <= cmd_i.out_status;
      slot_index  <= SLOT_W'(res_slot);
      entry_count <= COUNT_W'(count);
    end
  end

  assign stat_o.hit      = (rdata == key_reg);
  assign stat_o.empty    = (rdata == '0);
  assign stat_o.clr_last = (pos == LAST_IDX);

endmodule

`default_nettype wire

// ===== rtl/htfi_ctrl.sv =====
// ----------------------------------------------------------------------------
// htfi_ctrl
// Controller: sequences hashing, slot reduction, probing, table clears and
// the output register handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module htfi_ctrl #(
  parameter int TABLE_ENTRIES = htfi_pkg::DEF_TABLE_ENTRIES,
  parameter int MAX_PROBES    = htfi_pkg::DEF_MAX_PROBES
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       cmd,
  input  wire logic [htfi_pkg::KEY_W-1:0] key,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  input  wire htfi_pkg::dp_stat_t         stat_i,
  output htfi_pkg::dp_cmd_t               cmd_o
);
  import htfi_pkg::*;

  localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
  localparam int PRB_W = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
  localparam logic [PRB_W-1:0] PRB_LAST = PRB_W'(MAX_PROBES - 1);
  localparam logic [2:0] MUL_LAST_STEP = 3'd2;
  localparam logic [2:0] MOD_LAST_STEP = 3'(MOD_STEPS - 1);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLR, S_MUL, S_MOD, S_HOME, S_ISSUE, S_CHECK, S_EMIT
  } state_t;

  state_t              state;
  logic [2:0]          step;
  logic                pass;
  logic [PRB_W-1:0]    probe;
  logic                boot;
  logic [STATUS_W-1:0] res_status;

  logic accept;
  logic out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd_o            = '0;
    cmd_o.load       = accept;
    cmd_o.mul_const  = pass;
    cmd_o.out_status = res_status;
    case (step)
      3'd0:    cmd_o.mul_phase = MUL_LL;
      3'd1:    cmd_o.mul_phase = MUL_LH;
      default: cmd_o.mul_phase = MUL_HL;
    endcase
    case (state)
      S_INIT:  cmd_o.clr_start = 1'b1;
      S_CLR: begin
        cmd_o.clr_en  = 1'b1;
        cmd_o.cnt_clr = stat_i.clr_last;
      end
      S_MUL:   cmd_o.mul_en  = 1'b1;
      S_MOD:   cmd_o.mod_en  = 1'b1;
      S_HOME:  cmd_o.home    = 1'b1;
      S_ISSUE: cmd_o.advance = 1'b1;
      S_CHECK: begin
        if (stat_i.hit) begin
          cmd_o.slot_load = 1'b1;
        end else if (stat_i.empty) begin
          cmd_o.insert    = 1'b1;
          cmd_o.cnt_inc   = 1'b1;
          cmd_o.slot_load = 1'b1;
        end else if (probe != PRB_LAST) begin
          cmd_o.advance   = 1'b1;
        end
      end
      S_EMIT:  cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      step       <= '0;
      pass       <= 1'b0;
      probe      <= '0;
      boot       <= 1'b1;
      res_status <= ST_FOUND;
      out_valid  <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_INIT: begin
          boot  <= 1'b1;
          state <= S_CLR;
        end
        S_IDLE: begin
          if (accept) begin
            step <= '0;
            pass <= 1'b0;
            if (cmd) begin
              boot  <= 1'b0;
              state <= S_CLR;
            end else if (key == '0) begin
              res_status <= ST_ZERO_KEY;
              state      <= S_EMIT;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_CLR: begin
          if (stat_i.clr_last) begin
            res_status <= ST_CLEARED;
            state      <= boot ? S_IDLE : S_EMIT;
          end
        end
        S_MUL: begin
          if (step == MUL_LAST_STEP) begin
            step <= '0;
            if (pass) begin
              state <= IS_POW2 ? S_HOME : S_MOD;
            end else begin
              pass <= 1'b1;
            end
          end else begin
            step <= step + 1'b1;
          end
        end
        S_MOD: begin
          if (step == MOD_LAST_STEP) begin
            state <= S_HOME;
          end
          step <= step + 1'b1;
        end
        S_HOME:  state <= S_ISSUE;
        S_ISSUE: begin
          probe <= '0;
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (stat_i.hit) begin
            res_status <= ST_FOUND;
            state      <= S_EMIT;
          end else if (stat_i.empty) begin
            res_status <= ST_INSERTED;
            state      <= S_EMIT;
          end else if (probe == PRB_LAST) begin
            res_status <= ST_FULL;
            state      <= S_EMIT;
          end else begin
            probe <= probe + 1'b1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_INIT;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hash_table_find_or_insert.sv =====
// ----------------------------------------------------------------------------
// hash_table_find_or_insert
// Open-addressed key table with linear probing from a murmur-mixed home slot.
//
// Request channel: in_valid/in_stall with cmd and key. cmd 0 looks the key
// up and claims the first empty slot if it is absent; cmd 1 clears the table.
// Result channel: out_valid/out_stall with status, slot_index, entry_count,
// one result per request, in request order.
// A lookup hashes the key on one shared 32x32 multiplier, loads the home
// slot, primes the registered table read, makes 1 to MAX_PROBES probes and
// loads the output. A table size that is not a power of two adds remainder
// steps after the hashing. A zero key skips the hashing and goes straight
// to the output. A clear sweeps the table memory one slot per cycle.
// After reset the same sweep runs with in_stall high and no result. A
// stalled result sits in the output register while the next request is
// already being worked on.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module hash_table_find_or_insert #(
  parameter int TABLE_ENTRIES = htfi_pkg::DEF_TABLE_ENTRIES,
  parameter int MAX_PROBES    = htfi_pkg::DEF_MAX_PROBES
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          cmd,
  input  wire logic [htfi_pkg::KEY_W-1:0]    key,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [htfi_pkg::STATUS_W-1:0] status,
  output logic      [htfi_pkg::SLOT_W-1:0]   slot_index,
  output logic      [htfi_pkg::COUNT_W-1:0]  entry_count
);
  import htfi_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  htfi_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .MAX_PROBES   (MAX_PROBES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .key      (key),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stat_i   (dp_stat),
    .cmd_o    (dp_cmd)
  );

  htfi_dp #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .cmd_i      (dp_cmd),
    .key        (key),
    .stat_o     (dp_stat),
    .status     (status),
    .slot_index (slot_index),
    .entry_count(entry_count)
  );

  `HT_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "accepted while busy")
  `HT_ASSERT(a_clear_result, out_valid && status == ST_CLEARED |-> entry_count == '0 && slot_index == '0, "clear result not zero")
  `HT_ASSERT(a_no_slot, out_valid && (status == ST_FULL || status == ST_ZERO_KEY) |-> slot_index == '0, "slot on failed request")
  `HT_ASSERT_ALWAYS(a_stall_after_reset, rst |=> in_stall, "request taken during reset sweep")

endmodule

`default_nettype wire
